/* sv/tocq_pkg.sv */
// Package for the timed on/off condition qualifier: types, codes and widths
`timescale 1ns / 1ps

package tocq_pkg;

  // timestamp width, fixed by the now_us and recheck_at fields
  localparam int unsigned TimeBits = 48;
  // width of the minimum hold time registers
  localparam int unsigned HoldBits = 32;

  // tristate condition result codes
  localparam logic [1:0] COND_UNDEF = 2'd0;
  localparam logic [1:0] COND_FALSE = 2'd1;
  localparam logic [1:0] COND_TRUE  = 2'd2;

  // switch state codes
  localparam logic [1:0] ST_UNDEF = 2'd0;
  localparam logic [1:0] ST_OFF   = 2'd1;
  localparam logic [1:0] ST_ON    = 2'd2;

  // report mode codes, the fourth code reports nothing like MODE_NONE
  localparam logic [1:0] MODE_LEVEL  = 2'd0;
  localparam logic [1:0] MODE_ROCKER = 2'd1;
  localparam logic [1:0] MODE_NONE   = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_MIN_ON_TIME  = 2'd0;
  localparam logic [1:0] CFG_MIN_OFF_TIME = 2'd1;
  localparam logic [1:0] CFG_REPORT_MODE  = 2'd2;

  // input beat
  typedef struct packed {
    logic [1:0]          on_result;
    logic [1:0]          off_result;
    logic [TimeBits-1:0] now_us;
  } in_item_t;

  // result beat
  typedef struct packed {
    logic [1:0]          output_state;
    logic                level_valid;
    logic                level;
    logic                click_valid;
    logic                click_up;
    logic                recheck_valid;
    logic [TimeBits-1:0] recheck_at;
  } out_item_t;

  // configuration register set
  typedef struct packed {
    logic [HoldBits-1:0] min_on_time;
    logic [HoldBits-1:0] min_off_time;
    logic [1:0]          report_mode;
  } cfg_t;

  // qualifier state carried from one beat to the next
  typedef struct packed {
    logic [1:0]          switch_state;
    logic                timing_on;
    logic [TimeBits-1:0] met_since;
    logic                met_since_valid;
  } qual_state_t;

endpackage

/* sv/tocq_eval.sv */
// Decision logic for one beat: hold timing, switch decision and report fields
`timescale 1ns / 1ps

module tocq_eval (
  input  tocq_pkg::cfg_t        cfg_i,
  input  tocq_pkg::qual_state_t state_i,
  input  tocq_pkg::in_item_t    item_i,
  output tocq_pkg::qual_state_t state_o,
  output tocq_pkg::out_item_t   result_o
);
  import tocq_pkg::*;

  logic                on_true, off_true;
  logic                not_on, not_off;
  logic                on_path, off_path, phase2;
  logic                clr_on, clr_off, msv_mid;
  logic                start_on, start_off;
  logic [TimeBits-1:0] since, due;
  logic [HoldBits-1:0] hold;
  logic [TimeBits:0]   sum;
  logic                met, decided, recheck;
  logic [1:0]          new_state;

  // condition decode and path selection
  always_comb begin
    on_true  = (item_i.on_result == COND_TRUE);
    off_true = (item_i.off_result == COND_TRUE);
    not_on   = (state_i.switch_state != ST_ON);
    not_off  = (state_i.switch_state != ST_OFF);
    on_path  = not_on && on_true;
    clr_on   = not_on && !on_true && state_i.timing_on;
    msv_mid  = state_i.met_since_valid && !clr_on;
    start_on = on_path && (!state_i.timing_on || !state_i.met_since_valid);
    phase2   = !on_path && not_off;
    off_path = phase2 && off_true;
    clr_off  = phase2 && !off_true && !state_i.timing_on;
    start_off = off_path && (state_i.timing_on || !msv_mid);
  end

  // shared due time adder, saturating at the largest timestamp
  always_comb begin
    since   = (start_on || start_off) ? item_i.now_us : state_i.met_since;
    hold    = on_path ? cfg_i.min_on_time : cfg_i.min_off_time;
    sum     = {1'b0, since} + {{(TimeBits - HoldBits + 1){1'b0}}, hold};
    due     = sum[TimeBits] ? {TimeBits{1'b1}} : sum[TimeBits-1:0];
    met     = (item_i.now_us >= due);
    decided = (on_path || off_path) && met;
    recheck = (on_path || off_path) && !met;
  end

  // next state
  always_comb begin
    new_state = state_i.switch_state;
    if (decided) begin
      new_state = on_path ? ST_ON : ST_OFF;
    end
    state_o.switch_state = new_state;
    state_o.timing_on    = start_on ? 1'b1 : (start_off ? 1'b0 : state_i.timing_on);
    state_o.met_since    = (start_on || start_off) ? item_i.now_us : state_i.met_since;
    if (start_on || start_off) begin
      state_o.met_since_valid = 1'b1;
    end else if (clr_on || clr_off) begin
      state_o.met_since_valid = 1'b0;
    end else begin
      state_o.met_since_valid = state_i.met_since_valid;
    end
  end

  // report fields
  always_comb begin
    result_o.output_state  = new_state;
    result_o.recheck_valid = recheck;
    result_o.recheck_at    = recheck ? due : '0;
    result_o.level_valid   = decided && (cfg_i.report_mode == MODE_LEVEL);
    result_o.level         = result_o.level_valid && (new_state == ST_ON);
    result_o.click_valid   = decided && (cfg_i.report_mode == MODE_ROCKER) &&
                             (new_state != state_i.switch_state);
    result_o.click_up      = result_o.click_valid && (new_state == ST_ON);
  end

endmodule

/* sv/timed_on_off_condition_qualifier_core.sv */
// Top level of the timed on/off condition qualifier: handshakes, registers, state
`timescale 1ns / 1ps

// An accepted input beat is held in the input register and evaluated there; its
// result beat is written to the result register when that register is free.
// Throughput: one beat per cycle while out_stall_i is low; the state update
// sits in the single evaluation stage between the input and result registers.
// Reset: asynchronous, clears the switch state to undefined, the hold timing,
// min_on_time and min_off_time to 0 and report_mode to 2 (report nothing).
module timed_on_off_condition_qualifier_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  tocq_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output tocq_pkg::out_item_t  out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [1:0]           cfg_index_i,
  input  logic [31:0]          cfg_data_i
);
  import tocq_pkg::*;

  cfg_t        cfg_q;
  qual_state_t state_q, state_d;
  in_item_t    item_q;
  logic        item_valid_q;
  out_item_t   result_d, result_q;
  logic        out_valid_q;
  logic        out_free, advance, in_accept;

  // handshake control
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign advance     = item_valid_q && out_free;
  assign in_stall_o  = item_valid_q && !out_free;
  assign in_accept   = in_valid_i && !in_stall_o;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_on_time  <= '0;
      cfg_q.min_off_time <= '0;
      cfg_q.report_mode  <= MODE_NONE;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_MIN_ON_TIME:  cfg_q.min_on_time  <= cfg_data_i[HoldBits-1:0];
        CFG_MIN_OFF_TIME: cfg_q.min_off_time <= cfg_data_i[HoldBits-1:0];
        CFG_REPORT_MODE:  cfg_q.report_mode  <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_accept) begin
      item_valid_q <= 1'b1;
    end else if (advance) begin
      item_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q <= in_data_i;
    end
  end

  // evaluation of the held beat
  tocq_eval u_eval (
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .item_i   (item_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  // qualifier state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.switch_state    <= ST_UNDEF;
      state_q.timing_on       <= 1'b0;
      state_q.met_since       <= '0;
      state_q.met_since_valid <= 1'b0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= item_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = result_q;

`ifndef SYNTHESIS
  // once decided, the switch never falls back to undefined
  a_state_stays_defined: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.switch_state != ST_UNDEF) |=> (state_q.switch_state != ST_UNDEF))
    else $error("switch state returned to undefined");

  // the input side only stalls while a beat is held
  a_stall_only_when_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !item_valid_q |-> !in_stall_o)
    else $error("input stalled with empty input register");

  // a decision report never comes with a recheck and never leaves the state undefined
  a_report_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.level_valid || out_data_o.click_valid)) |->
    (!out_data_o.recheck_valid && (out_data_o.output_state != ST_UNDEF)))
    else $error("decision report overlaps recheck or undefined state");

  // a click beat follows a state change recorded in the state register
  a_click_changes_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && result_d.click_valid) |=> (state_q.switch_state != $past(state_q.switch_state)))
    else $error("click without a state change");
`endif

endmodule

/* dv/testbench.sv */
// Testbench for the timed on/off condition qualifier core: directed and random beats vs a predictor
`timescale 1ns / 1ps

module testbench;
  import tocq_pkg::*;

  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned IdlePercent  = 28;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned MaxReports   = 10;
  localparam int unsigned RandomPhases = 8;
  localparam int unsigned PhaseBeats   = 100;

  // out-of-list codes: condition result three and the unused register index
  localparam logic [1:0] CondReserved = 2'd3;
  localparam logic [1:0] CfgUnused    = 2'd3;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  in_item_t            in_data_i;
  logic                out_valid_o;
  logic                out_stall_i;
  out_item_t           out_data_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [1:0]          cfg_index_i;
  logic [31:0]         cfg_data_i;

  // predictor copies of the registers and the qualifier state
  cfg_t                cfg_model;
  qual_state_t         qual_model;
  out_item_t           pending_results[$];
  out_item_t           wanted;

  logic                quiet;
  logic [TimeBits-1:0] clock_us;
  int unsigned         cycles;
  int unsigned         failures;
  int unsigned         beats_sent;
  int unsigned         results_seen;
  int unsigned         level_reports;
  int unsigned         click_reports;
  int unsigned         recheck_reports;

  timed_on_off_condition_qualifier_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_results.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver stalls at random unless in a quiet stretch
  always @(negedge clk_i) begin
    out_stall_i = !quiet && ($urandom_range(0, 99) < IdlePercent);
  end

  // due time: start plus hold, clipped at the largest timestamp
  function automatic logic [TimeBits-1:0] hold_due(logic [TimeBits-1:0] since,
                                                   logic [HoldBits-1:0] hold);
    logic [TimeBits:0] sum;
    sum = {1'b0, since} + hold;
    return sum[TimeBits] ? {TimeBits{1'b1}} : sum[TimeBits-1:0];
  endfunction

  // advance the predicted qualifier by one input beat, return its result
  function automatic out_item_t qualify_beat(in_item_t beat);
    out_item_t           res;
    logic                on_true;
    logic                off_true;
    logic                decided;
    logic                recheck;
    logic [1:0]          prev;
    logic [TimeBits-1:0] due;
    res      = '0;
    on_true  = (beat.on_result == COND_TRUE);
    off_true = (beat.off_result == COND_TRUE);
    prev     = qual_model.switch_state;
    decided  = 1'b0;
    recheck  = 1'b0;
    due      = '0;

    // on condition, timed while not on
    if (qual_model.switch_state != ST_ON) begin
      if (!on_true) begin
        if (qual_model.timing_on) qual_model.met_since_valid = 1'b0;
      end else begin
        if (!qual_model.timing_on || !qual_model.met_since_valid) begin
          qual_model.timing_on       = 1'b1;
          qual_model.met_since       = beat.now_us;
          qual_model.met_since_valid = 1'b1;
        end
        due = hold_due(qual_model.met_since, cfg_model.min_on_time);
        if (beat.now_us >= due) begin
          qual_model.switch_state = ST_ON;
          decided = 1'b1;
        end else begin
          recheck = 1'b1;
        end
      end
    end

    // off condition, only when the on side left the step open
    if (!recheck && !decided && qual_model.switch_state != ST_OFF) begin
      if (!off_true) begin
        if (!qual_model.timing_on) qual_model.met_since_valid = 1'b0;
      end else begin
        if (qual_model.timing_on || !qual_model.met_since_valid) begin
          qual_model.timing_on       = 1'b0;
          qual_model.met_since       = beat.now_us;
          qual_model.met_since_valid = 1'b1;
        end
        due = hold_due(qual_model.met_since, cfg_model.min_off_time);
        if (beat.now_us >= due) begin
          qual_model.switch_state = ST_OFF;
          decided = 1'b1;
        end else begin
          recheck = 1'b1;
        end
      end
    end

    // reporting
    if (recheck) begin
      res.recheck_valid = 1'b1;
      res.recheck_at    = due;
    end else if (decided && qual_model.switch_state != ST_UNDEF) begin
      case (cfg_model.report_mode)
        MODE_LEVEL: begin
          res.level_valid = 1'b1;
          res.level       = (qual_model.switch_state == ST_ON);
        end
        MODE_ROCKER: begin
          if (qual_model.switch_state != prev) begin
            res.click_valid = 1'b1;
            res.click_up    = (qual_model.switch_state == ST_ON);
          end
        end
        default: ;
      endcase
    end
    res.output_state = qual_model.switch_state;
    return res;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen <= results_seen + 1;
      if (pending_results.size() == 0) begin
        failures = failures + 1;
        if (failures <= MaxReports)
          $display("unexpected result beat %h", out_data_o);
      end else begin
        wanted = pending_results.pop_front();
        if (out_data_o.output_state !== wanted.output_state ||
            out_data_o.level_valid !== wanted.level_valid ||
            out_data_o.level !== wanted.level ||
            out_data_o.click_valid !== wanted.click_valid ||
            out_data_o.click_up !== wanted.click_up ||
            out_data_o.recheck_valid !== wanted.recheck_valid ||
            out_data_o.recheck_at !== wanted.recheck_at) begin
          failures = failures + 1;
          if (failures <= MaxReports) begin
            $display("result %0d mismatch: expected st=%0d lvl=%b/%b clk=%b/%b rchk=%b/%h",
                     results_seen, wanted.output_state, wanted.level_valid, wanted.level,
                     wanted.click_valid, wanted.click_up, wanted.recheck_valid,
                     wanted.recheck_at);
            $display("                      actual   st=%0d lvl=%b/%b clk=%b/%b rchk=%b/%h",
                     out_data_o.output_state, out_data_o.level_valid, out_data_o.level,
                     out_data_o.click_valid, out_data_o.click_up, out_data_o.recheck_valid,
                     out_data_o.recheck_at);
          end
        end
        if (wanted.level_valid) level_reports <= level_reports + 1;
        if (wanted.click_valid) click_reports <= click_reports + 1;
        if (wanted.recheck_valid) recheck_reports <= recheck_reports + 1;
      end
    end
  end

  // send one input beat; entered and left at a falling edge
  task automatic send_beat(logic [1:0] on_r, logic [1:0] off_r, logic [TimeBits-1:0] stamp);
    in_item_t beat;
    beat.on_result  = on_r;
    beat.off_result = off_r;
    beat.now_us     = stamp;
    while (!quiet && ($urandom_range(0, 99) < IdlePercent)) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i  = beat;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(qualify_beat(beat));
    beats_sent = beats_sent + 1;
    @(negedge clk_i);
  endtask

  // stop sending and wait for every expected result
  task automatic wait_results_drained();
    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  // register write, only with the block idle
  task automatic write_reg(logic [1:0] index, logic [31:0] data);
    wait_results_drained();
    cfg_valid_i = 1'b1;
    cfg_index_i = index;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (index)
      CFG_MIN_ON_TIME:  cfg_model.min_on_time  = data;
      CFG_MIN_OFF_TIME: cfg_model.min_off_time = data;
      CFG_REPORT_MODE:  cfg_model.report_mode  = data[1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // reset register values, state still undefined
  task automatic test_reset_state();
    send_beat(COND_UNDEF, COND_UNDEF, 48'd0);
    send_beat(CondReserved, CondReserved, 48'd0);
    send_beat(COND_FALSE, COND_FALSE, 48'd1);
  endtask

  // from undefined, a pending on timing ends the step before the off side
  task automatic test_undefined_priority();
    write_reg(CFG_REPORT_MODE, {30'd0, MODE_LEVEL});
    write_reg(CFG_MIN_ON_TIME, 32'd10);
    write_reg(CFG_MIN_OFF_TIME, 32'd0);
    send_beat(COND_TRUE, COND_TRUE, 48'd5);
    send_beat(COND_FALSE, COND_TRUE, 48'd6);
  endtask

  // level mode with hold times, including a broken hold
  task automatic test_level_reports();
    write_reg(CFG_MIN_OFF_TIME, 32'd5);
    send_beat(COND_TRUE, COND_UNDEF, 48'd100);
    send_beat(COND_TRUE, COND_FALSE, 48'd104);
    send_beat(COND_FALSE, COND_FALSE, 48'd106);
    send_beat(COND_TRUE, COND_FALSE, 48'd107);
    send_beat(COND_TRUE, COND_FALSE, 48'd117);
    send_beat(COND_FALSE, COND_TRUE, 48'd118);
    send_beat(COND_FALSE, COND_TRUE, 48'd123);
  endtask

  // rocker mode clicks only on a change
  task automatic test_rocker_clicks();
    write_reg(CFG_REPORT_MODE, {30'd0, MODE_ROCKER});
    write_reg(CFG_MIN_ON_TIME, 32'd0);
    write_reg(CFG_MIN_OFF_TIME, 32'd0);
    send_beat(COND_TRUE, COND_FALSE, 48'd200);
    send_beat(COND_TRUE, COND_FALSE, 48'd201);
    send_beat(COND_FALSE, COND_TRUE, 48'd202);
    send_beat(COND_FALSE, COND_TRUE, 48'd203);
  endtask

  // largest hold times: saturated due time and time going backwards
  task automatic test_timestamp_extremes();
    write_reg(CFG_REPORT_MODE, {30'd0, MODE_LEVEL});
    write_reg(CFG_MIN_ON_TIME, 32'hFFFF_FFFF);
    write_reg(CFG_MIN_OFF_TIME, 32'hFFFF_FFFF);
    send_beat(COND_TRUE, COND_UNDEF, 48'hFFFF_FFFF_FF00);
    send_beat(COND_TRUE, COND_UNDEF, 48'hFFFF_FFFF_FFFF);
    send_beat(COND_UNDEF, COND_TRUE, 48'd0);
    send_beat(COND_UNDEF, COND_TRUE, 48'h0001_0000_0000);
  endtask

  // fourth report mode and the unused register index
  task automatic test_odd_codes();
    write_reg(CFG_REPORT_MODE, 32'hFFFF_FFFF);
    write_reg(CFG_MIN_ON_TIME, 32'd0);
    write_reg(CFG_MIN_OFF_TIME, 32'd0);
    write_reg(CfgUnused, 32'hA5A5_5A5A);
    send_beat(COND_TRUE, CondReserved, 48'h5555_AAAA_5555);
    send_beat(CondReserved, COND_TRUE, 48'h5555_AAAA_5556);
  endtask

  // pick a hold time: mostly short, sometimes zero, full scale or random
  function automatic logic [31:0] pick_hold();
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2, 3:    return $urandom();
      default: return $urandom_range(1, 40);
    endcase
  endfunction

  // move the timestamp: mostly forward, sometimes back or to anywhere
  task automatic advance_clock(int unsigned span);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 88) begin
      clock_us = clock_us + $urandom_range(0, span);
    end else if (pick < 93) begin
      clock_us = clock_us - $urandom_range(0, span);
    end else if (pick < 96) begin
      clock_us = {TimeBits{1'b1}} - $urandom_range(0, span);
    end else begin
      clock_us[47:32] = 16'($urandom());
      clock_us[31:0]  = $urandom();
    end
  endtask

  // random settings, mostly runs that hold one condition long enough
  task automatic test_random_traffic();
    int unsigned sent;
    int unsigned run_len;
    int unsigned span;
    logic [31:0] on_hold;
    logic [31:0] off_hold;
    logic        target_on;
    logic        held_off;
    logic [1:0]  on_r;
    logic [1:0]  off_r;
    clock_us = '0;
    for (int phase = 0; phase < RandomPhases; phase++) begin
      on_hold  = (phase == 0) ? 32'd0 : (phase == 1) ? 32'hFFFF_FFFF : pick_hold();
      off_hold = (phase == 0) ? 32'hFFFF_FFFF : (phase == 1) ? 32'd0 : pick_hold();
      write_reg(CFG_MIN_ON_TIME, on_hold);
      write_reg(CFG_MIN_OFF_TIME, off_hold);
      write_reg(CFG_REPORT_MODE, (phase < 4) ? phase : $urandom());
      span     = ((on_hold > off_hold) ? on_hold : off_hold) / 3 + 2;
      quiet    = (phase == 3);
      held_off = (phase != 5);
      sent     = 0;
      while (sent < PhaseBeats) begin
        // sender holds back once until the block has drained
        if (!held_off && sent >= PhaseBeats / 2) begin
          wait_results_drained();
          held_off = 1'b1;
        end
        if ($urandom_range(0, 3) != 0) begin
          target_on = 1'($urandom_range(0, 1));
          run_len   = $urandom_range(2, 10);
          for (int k = 0; k < run_len; k++) begin
            on_r  = 2'($urandom_range(0, 3));
            off_r = 2'($urandom_range(0, 3));
            if ($urandom_range(0, 9) != 0) begin
              if (target_on) on_r = COND_TRUE;
              else off_r = COND_TRUE;
            end
            advance_clock(span);
            send_beat(on_r, off_r, clock_us);
            sent++;
          end
        end else begin
          run_len = $urandom_range(1, 4);
          for (int k = 0; k < run_len; k++) begin
            advance_clock(span);
            send_beat(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), clock_us);
            sent++;
          end
        end
      end
      wait_results_drained();
    end
    quiet = 1'b0;
  endtask

  initial begin
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    in_data_i       = '0;
    out_stall_i     = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = CFG_MIN_ON_TIME;
    cfg_data_i      = '0;
    quiet           = 1'b0;
    clock_us        = '0;
    cycles          = 0;
    failures        = 0;
    beats_sent      = 0;
    results_seen    = 0;
    level_reports   = 0;
    click_reports   = 0;
    recheck_reports = 0;
    cfg_model.min_on_time  = '0;
    cfg_model.min_off_time = '0;
    cfg_model.report_mode  = MODE_NONE;
    qual_model = '0;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_state();
    test_undefined_priority();
    test_level_reports();
    test_rocker_clicks();
    test_timestamp_extremes();
    test_odd_codes();
    test_random_traffic();

    wait_results_drained();
    repeat (SettleCycles) @(negedge clk_i);

    $display("%0d beats sent, %0d results: %0d level reports, %0d clicks, %0d rechecks",
             beats_sent, results_seen, level_reports, click_reports, recheck_reports);
    $display("random part swept %0d register settings, %0d cycles in all",
             RandomPhases, cycles);
    if (failures == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d failures", failures);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/tocq_pkg.sv
sv/tocq_eval.sv
sv/timed_on_off_condition_qualifier_core.sv
dv/testbench.sv
